>>> design/ame_pkg.sv
// shared types and constants for the accumulator machine execute block
// opcodes, status codes, state encodings, stream field widths
// no dependencies
package ame_pkg;

  localparam int unsigned KIND_W   = 4;
  localparam int unsigned LOC_W    = 3;
  localparam int unsigned ACC_W    = 64;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned S_TDATA_W = ((LOC_W + ACC_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((ACC_W + STATUS_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    OP_MOV = 4'd0,
    OP_ADD = 4'd1,
    OP_SUB = 4'd2,
    OP_LD  = 4'd3,
    OP_ST  = 4'd4,
    OP_MUL = 4'd5,
    OP_DIV = 4'd6,
    OP_AND = 4'd7,
    OP_OR  = 4'd8,
    OP_NOT = 4'd9,
    OP_HLT = 4'd10
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_BADLOC  = 3'd1,
    ST_DIVZERO = 3'd2,
    ST_BADOP   = 3'd3,
    ST_HALTED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    A_ADD,
    A_SUB,
    A_MUL,
    A_DIV
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef enum logic [2:0] {
    AR_IDLE,
    AR_ONE,
    AR_NEG_A,
    AR_NEG_B,
    AR_ITER,
    AR_FIX
  } arith_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_BUSY,
    T_HOLD
  } top_state_t;

endpackage

>>> design/ame_arith.sv
// iterative arithmetic unit: add, subtract, shift-add multiply, restoring divide
// all steps go through one shared adder/subtractor under a small sequencer
// depends on ame_pkg
module ame_arith #(
  parameter int unsigned W = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  ame_pkg::arith_req_t req,
  input  logic [W-1:0]        a,
  input  logic [W-1:0]        b,
  output logic                done,
  output logic [W-1:0]        result
);
  import ame_pkg::*;

  localparam int unsigned CNT_W = $clog2(W);

  arith_state_t   state, state_next;
  arith_op_t      op;
  logic [W-1:0]   a_r, b_r, p_r, res;
  logic [CNT_W-1:0] cnt;
  logic           neg_q, done_r;
  logic [W-1:0]   add_x, add_y, rem_sh;
  logic           add_sub;
  logic [W:0]     sum;
  logic           last;

  assign rem_sh = {p_r[W-2:0], a_r[W-1]};
  assign last   = (cnt == CNT_W'(W - 1));
  assign sum    = {1'b0, add_x} + {1'b0, add_y ^ {W{add_sub}}} + (W + 1)'(add_sub);
  assign done   = done_r;
  assign result = res;

  always_comb begin
    state_next = state;
    unique case (state)
      AR_IDLE: begin
        if (req.start) begin
          unique case (req.op)
            A_ADD, A_SUB: state_next = AR_ONE;
            A_MUL:        state_next = AR_ITER;
            A_DIV:        state_next = AR_NEG_A;
          endcase
        end
      end
      AR_ONE:   state_next = AR_IDLE;
      AR_NEG_A: state_next = AR_NEG_B;
      AR_NEG_B: state_next = AR_ITER;
      AR_ITER: begin
        if (last) begin
          state_next = (op == A_DIV) ? AR_FIX : AR_IDLE;
        end
      end
      AR_FIX:   state_next = AR_IDLE;
      default:  state_next = AR_IDLE;
    endcase
  end

  // shared adder operand select
  always_comb begin
    add_x   = a_r;
    add_y   = b_r;
    add_sub = 1'b0;
    unique case (state)
      AR_ONE: begin
        add_sub = (op == A_SUB);
      end
      AR_NEG_A: begin
        add_x   = '0;
        add_y   = a_r;
        add_sub = 1'b1;
      end
      AR_NEG_B: begin
        add_x   = '0;
        add_y   = b_r;
        add_sub = 1'b1;
      end
      AR_ITER: begin
        if (op == A_DIV) begin
          add_x   = rem_sh;
          add_y   = b_r;
          add_sub = 1'b1;
        end else begin
          add_x = p_r;
          add_y = a_r;
        end
      end
      AR_FIX: begin
        add_x   = '0;
        add_y   = a_r;
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= AR_IDLE;
      done_r <= 1'b0;
    end else begin
      state  <= state_next;
      done_r <= (state == AR_ONE) || (state == AR_FIX) ||
                ((state == AR_ITER) && last && (op != A_DIV));
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      AR_IDLE: begin
        if (req.start) begin
          a_r   <= a;
          b_r   <= b;
          op    <= req.op;
          neg_q <= a[W-1] ^ b[W-1];
          p_r   <= '0;
          cnt   <= '0;
        end
      end
      AR_ONE: begin
        res <= sum[W-1:0];
      end
      AR_NEG_A: begin
        if (a_r[W-1]) begin
          a_r <= sum[W-1:0];
        end
      end
      AR_NEG_B: begin
        if (b_r[W-1]) begin
          b_r <= sum[W-1:0];
        end
      end
      AR_ITER: begin
        cnt <= cnt + 1'b1;
        if (op == A_DIV) begin
          // carry out means no borrow: partial remainder covers divisor
          p_r <= sum[W] ? sum[W-1:0] : rem_sh;
          a_r <= {a_r[W-2:0], sum[W]};
        end else begin
          if (b_r[0]) begin
            p_r <= sum[W-1:0];
          end
          a_r <= a_r << 1;
          b_r <= b_r >> 1;
          if (last) begin
            res <= b_r[0] ? sum[W-1:0] : p_r;
          end
        end
      end
      AR_FIX: begin
        res <= neg_q ? sum[W-1:0] : a_r;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/accumulator_machine_execute_top.sv
// One instruction per input beat for an accumulator machine with a DATA_WIDTH-bit signed
// accumulator and NUM_LOCATIONS storage locations; one result beat per input beat. The
// block takes one instruction at a time. Add, subtract, multiply and divide go through
// ame_arith; every other instruction and every error completes in the top level alone.
// Multiply and divide run one bit per cycle through the shared adder in ame_arith.
// A finished result waits in the output register while the next beat is taken.
// depends on ame_pkg and ame_arith
module accumulator_machine_execute_top #(
  parameter int NUM_LOCATIONS = 5,
  parameter int DATA_WIDTH    = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // location [2:0], immediate [66:3], zero pad
  input  logic [ame_pkg::S_TDATA_W-1:0] s_tdata,
  // kind [3:0]
  input  logic [ame_pkg::KIND_W-1:0]    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // acc_value [63:0], status [66:64], zero pad
  output logic [ame_pkg::M_TDATA_W-1:0] m_tdata
);
  import ame_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  top_state_t   state, state_next;
  logic [W-1:0] acc, acc_next, mem_val, unit_res;
  logic [W-1:0] store [NUM_LOCATIONS];
  logic         halted;
  status_t      status_next, status_r;
  logic [KIND_W-1:0] kind;
  logic [LOC_W-1:0]  location;
  logic [ACC_W-1:0]  immediate;
  logic         loc_ok, accept, acc_wr, store_wr, halt_set, unit_go, unit_done, out_load;
  arith_op_t    unit_op;
  arith_req_t   unit_req;

  assign kind      = s_tuser;
  assign location  = s_tdata[LOC_W-1:0];
  assign immediate = s_tdata[LOC_W +: ACC_W];
  assign accept    = s_tvalid && s_tready;
  assign loc_ok    = 32'(location) < NUM_LOCATIONS;

  always_comb begin
    mem_val = '0;
    for (int i = 0; i < NUM_LOCATIONS; i++) begin
      if (32'(location) == i) begin
        mem_val = store[i];
      end
    end
  end

  // instruction decode
  always_comb begin
    status_next = ST_OK;
    acc_next    = acc;
    acc_wr      = 1'b0;
    store_wr    = 1'b0;
    halt_set    = 1'b0;
    unit_go     = 1'b0;
    unit_op     = A_ADD;
    if (halted) begin
      status_next = ST_HALTED;
    end else if (kind > OP_HLT) begin
      status_next = ST_BADOP;
    end else if (kind == OP_MOV) begin
      acc_wr   = 1'b1;
      acc_next = immediate[W-1:0];
    end else if (kind == OP_NOT) begin
      acc_wr   = 1'b1;
      acc_next = ~acc;
    end else if (kind == OP_HLT) begin
      halt_set    = 1'b1;
      status_next = ST_HALTED;
    end else if (!loc_ok) begin
      status_next = ST_BADLOC;
    end else begin
      case (kind)
        OP_ADD: begin
          unit_go = 1'b1;
          unit_op = A_ADD;
        end
        OP_SUB: begin
          unit_go = 1'b1;
          unit_op = A_SUB;
        end
        OP_LD: begin
          acc_wr   = 1'b1;
          acc_next = mem_val;
        end
        OP_ST: begin
          store_wr = 1'b1;
          acc_wr   = 1'b1;
          acc_next = '0;
        end
        OP_MUL: begin
          unit_go = 1'b1;
          unit_op = A_MUL;
        end
        OP_DIV: begin
          if (mem_val == '0) begin
            status_next = ST_DIVZERO;
          end else begin
            unit_go = 1'b1;
            unit_op = A_DIV;
          end
        end
        OP_AND: begin
          acc_wr   = 1'b1;
          acc_next = acc & mem_val;
        end
        OP_OR: begin
          acc_wr   = 1'b1;
          acc_next = acc | mem_val;
        end
        default: begin
        end
      endcase
    end
  end

  assign unit_req.start = accept && unit_go;
  assign unit_req.op    = unit_op;

  ame_arith #(
    .W (W)
  ) u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (unit_req),
    .a      (acc),
    .b      (mem_val),
    .done   (unit_done),
    .result (unit_res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE: begin
        if (accept) begin
          state_next = unit_go ? T_BUSY : T_HOLD;
        end
      end
      T_BUSY: begin
        if (unit_done) begin
          state_next = T_HOLD;
        end
      end
      T_HOLD: begin
        if (!m_tvalid || m_tready) begin
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == T_IDLE);
    out_load = (state == T_HOLD) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      acc      <= '0;
      halted   <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < NUM_LOCATIONS; i++) begin
        store[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (accept) begin
        if (acc_wr) begin
          acc <= acc_next;
        end
        if (halt_set) begin
          halted <= 1'b1;
        end
        for (int i = 0; i < NUM_LOCATIONS; i++) begin
          if (store_wr && (32'(location) == i)) begin
            store[i] <= acc;
          end
        end
      end
      if ((state == T_BUSY) && unit_done) begin
        acc <= unit_res;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_next;
    end
    if (out_load) begin
      m_tdata <= M_TDATA_W'({status_r, ACC_W'($signed(acc))});
    end
  end

endmodule

>>> design/ame_checker.sv
// port-level checks for accumulator_machine_execute_top, attached by bind
// depends on ame_pkg
module ame_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ame_pkg::M_TDATA_W-1:0] m_tdata
);

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat right after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  // one instruction at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an instruction is in flight");

  // a result only appears while the block is busy with its instruction
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result beat without a pending instruction");

endmodule

bind accumulator_machine_execute_top ame_checker u_ame_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
